// ----- rtl/core/nfve_pkg.sv -----
package nfve_pkg;

  // name register storage
  localparam int MAX_NAME_BYTES = 16;
  localparam int NAME_BITS      = 8 * MAX_NAME_BYTES;
  localparam int LEN_W          = 5;
  localparam int POS_W          = 5;

  // configuration register indexes
  localparam logic [1:0] REG_NAME_LOW  = 2'd0;
  localparam logic [1:0] REG_NAME_HIGH = 2'd1;
  localparam logic [1:0] REG_NAME_LEN  = 2'd2;

  // character codes
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_A      = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_BEL    = 8'h07;
  localparam logic [7:0] CH_TAB    = 8'h09;

  // value closing kinds
  localparam logic [1:0] CLOSE_SPACE  = 2'd0;
  localparam logic [1:0] CLOSE_DQUOTE = 2'd1;
  localparam logic [1:0] CLOSE_SQUOTE = 2'd2;

  // queue between parser and output side
  localparam int QUEUE_DEPTH = 4;

  // scan phases
  typedef enum logic [7:0] {
    PH_LEAD    = 8'b0000_0001,
    PH_NAME    = 8'b0000_0010,
    PH_POST    = 8'b0000_0100,
    PH_SKEY    = 8'b0000_1000,
    PH_SVSTART = 8'b0001_0000,
    PH_SVAL    = 8'b0010_0000,
    PH_VSTART  = 8'b0100_0000,
    PH_VAL     = 8'b1000_0000
  } phase_t;

  // one parsed byte: an optional value byte and an optional line-done result
  typedef struct packed {
    logic       char_vld;
    logic [7:0] value_char;
    logic       done;
    logic       found;
  } entry_t;

  function automatic logic is_ws(input logic [7:0] c);
    is_ws = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic [7:0] name_byte(input logic [NAME_BITS-1:0] name,
                                           input logic [3:0] idx);
    name_byte = name[8*idx +: 8];
  endfunction

  function automatic logic [7:0] closing_char(input logic [1:0] kind);
    case (kind)
      CLOSE_DQUOTE: closing_char = CH_DQUOTE;
      CLOSE_SQUOTE: closing_char = CH_SQUOTE;
      default:      closing_char = CH_SPACE;
    endcase
  endfunction

  function automatic logic [7:0] unescape(input logic [7:0] c);
    case (c)
      CH_N:    unescape = CH_LF;
      CH_R:    unescape = CH_CR;
      CH_A:    unescape = CH_BEL;
      default: unescape = c;
    endcase
  endfunction

endpackage

// ----- rtl/core/named_field_value_extractor_core.sv -----
// Named field value extractor: scans name=value lines for one configured field name.
// Input stream: one line byte per transfer, in_tdata[7:0] = line_char, in_tlast marks
// the last byte of a line. Output stream: in_tdata-style results, value_char in
// out_tdata[7:0] with out_tuser = char_valid, and a final result per line with
// out_tlast = value_done and out_tdata[8] = field_found.
// Configuration: cfg_index 0/1 load name bytes 0-7 / 8-15, index 2 the name length
// (0 passes every byte through). Write only while no line is in flight.
// Throughput: one input byte per cycle while the queue has room. A byte that yields
// a value byte and the line-done result together leaves as two output transfers,
// since the output register drains one result per cycle while out_tready is high;
// a 4-entry queue between the parser and the output register absorbs those bursts
// and receiver stalls. Results pass through the queue and then the output register
// before out_tvalid rises.
// When the receiver stalls, the queue fills and in_tready drops once it is full.
// Reset (rst_n low, synchronous) clears the name registers, the parse state, the
// queue fill state and the output valid and pending-done flags.
module named_field_value_extractor_core
  import nfve_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  // line byte stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] line_char
  input  logic        in_tlast,
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] value_char, [8] field_found, [15:9] zero
  output logic        out_tuser,  // [0] char_valid
  output logic        out_tlast
);

  logic   accept;
  logic   push;
  entry_t push_entry;
  logic   q_full;
  logic   q_not_empty;
  logic   q_pop;
  entry_t q_head;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // parser front end
  nfve_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .line_char  (in_tdata),
    .line_end   (in_tlast),
    .push       (push),
    .push_entry (push_entry)
  );

  // result queue
  nfve_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  // output serializer
  nfve_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule

// ----- rtl/core/nfve_front.sv -----
module nfve_front
  import nfve_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_valid,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  input  logic         accept,
  input  logic [7:0]   line_char,
  input  logic         line_end,
  output logic         push,
  output entry_t       push_entry
);

  logic [NAME_BITS-1:0] name_r;
  logic [LEN_W-1:0]     len_r;
  phase_t               phase_r, phase_nxt;
  logic [POS_W-1:0]     pos_r, pos_nxt;
  logic [1:0]           kind_r, kind_nxt;
  logic                 esc_r, esc_nxt;
  logic                 fin_r, fin_nxt;

  logic [LEN_W-1:0]     len_eff;
  logic                 do_name;
  logic                 go;
  logic [POS_W-1:0]     p;
  logic                 found;
  entry_t               ent;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_r <= '0;
      len_r  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_NAME_LOW:  name_r[63:0]   <= cfg_data;
        REG_NAME_HIGH: name_r[127:64] <= cfg_data;
        REG_NAME_LEN:  len_r          <= cfg_data[LEN_W-1:0];
        default:       ;
      endcase
    end
  end

  assign len_eff = (len_r > LEN_W'(MAX_NAME_BYTES)) ? LEN_W'(MAX_NAME_BYTES) : len_r;

  // parse one byte
  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    kind_nxt  = kind_r;
    esc_nxt   = esc_r;
    fin_nxt   = fin_r;
    ent       = '0;
    do_name   = 1'b0;
    go        = 1'b0;
    p         = pos_r;
    found     = 1'b0;

    if (len_eff == '0) begin
      // pass-through mode
      ent.char_vld   = 1'b1;
      ent.value_char = line_char;
      found          = 1'b1;
    end else begin
      case (phase_r)
        PH_NAME: do_name = 1'b1;
        PH_POST: begin
          if (line_char == CH_EQ) phase_nxt = PH_VSTART;
          else if (!is_ws(line_char)) phase_nxt = PH_SKEY;
        end
        PH_SKEY: begin
          if (line_char == CH_EQ) phase_nxt = PH_SVSTART;
        end
        PH_SVSTART, PH_SVAL: begin
          go = 1'b1;
          if (phase_r == PH_SVSTART) begin
            if (is_ws(line_char)) begin
              go = 1'b0;
            end else begin
              phase_nxt = PH_SVAL;
              if (line_char == CH_DQUOTE) begin
                kind_nxt = CLOSE_DQUOTE;
                go       = 1'b0;
              end else if (line_char == CH_SQUOTE) begin
                kind_nxt = CLOSE_SQUOTE;
                go       = 1'b0;
              end else begin
                kind_nxt = CLOSE_SPACE;
              end
            end
          end
          if (go) begin
            if (esc_r) begin
              esc_nxt = 1'b0;
            end else if (line_char == closing_char(kind_nxt)) begin
              phase_nxt = PH_LEAD;
              kind_nxt  = CLOSE_SPACE;
            end else if (line_char == CH_BSLASH) begin
              esc_nxt = 1'b1;
            end
          end
        end
        PH_VSTART, PH_VAL: begin
          if (!fin_r) begin
            go = 1'b1;
            if (phase_r == PH_VSTART) begin
              if (is_ws(line_char)) begin
                go = 1'b0;
              end else begin
                phase_nxt = PH_VAL;
                if (line_char == CH_DQUOTE) begin
                  kind_nxt = CLOSE_DQUOTE;
                  go       = 1'b0;
                end else if (line_char == CH_SQUOTE) begin
                  kind_nxt = CLOSE_SQUOTE;
                  go       = 1'b0;
                end else begin
                  kind_nxt = CLOSE_SPACE;
                end
              end
            end
            if (go) begin
              if (esc_r) begin
                esc_nxt        = 1'b0;
                ent.char_vld   = 1'b1;
                ent.value_char = unescape(line_char);
              end else if (line_char == closing_char(kind_nxt)) begin
                fin_nxt = 1'b1;
              end else if (line_char == CH_BSLASH) begin
                esc_nxt = 1'b1;
              end else begin
                ent.char_vld   = 1'b1;
                ent.value_char = line_char;
              end
            end
          end
        end
        default: begin
          // leading whitespace before a pair
          phase_nxt = PH_LEAD;
          pos_nxt   = '0;
          p         = '0;
          if (!is_ws(line_char)) do_name = 1'b1;
        end
      endcase

      // name compare step
      if (do_name) begin
        if ((p < len_eff) && (line_char == name_byte(name_r, p[3:0])) &&
            (line_char != CH_EQ)) begin
          pos_nxt   = p + POS_W'(1);
          phase_nxt = ((p + POS_W'(1)) >= len_eff) ? PH_POST : PH_NAME;
        end else begin
          pos_nxt   = '0;
          phase_nxt = (line_char == CH_EQ) ? PH_SVSTART : PH_SKEY;
        end
      end

      found = (phase_nxt == PH_VSTART) || (phase_nxt == PH_VAL);
    end

    // line end: done result and line state back to reset
    if (line_end) begin
      ent.done  = 1'b1;
      ent.found = found;
      phase_nxt = PH_LEAD;
      pos_nxt   = '0;
      kind_nxt  = CLOSE_SPACE;
      esc_nxt   = 1'b0;
      fin_nxt   = 1'b0;
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_LEAD;
      pos_r   <= '0;
      kind_r  <= CLOSE_SPACE;
      esc_r   <= 1'b0;
      fin_r   <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      kind_r  <= kind_nxt;
      esc_r   <= esc_nxt;
      fin_r   <= fin_nxt;
    end
  end

  assign push       = accept && (ent.char_vld || ent.done);
  assign push_entry = ent;

endmodule

// ----- rtl/core/nfve_queue.sv -----
module nfve_queue
  import nfve_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output logic   full,
  output logic   not_empty,
  output entry_t head
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t           slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_entry;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      case ({push, pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];

endmodule

// ----- rtl/core/nfve_back.sv -----
module nfve_back
  import nfve_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_not_empty,
  input  entry_t      q_head,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  output logic        out_tuser,
  output logic        out_tlast
);

  logic       vld_r;
  logic [7:0] char_r;
  logic       cvld_r;
  logic       done_r;
  logic       found_r;
  logic       pend_done_r;
  logic       pend_found_r;
  logic       out_free;

  assign out_free = !vld_r || out_tready;
  assign q_pop    = out_free && !pend_done_r && q_not_empty;

  // output register: value byte first, then the done result of the same entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= 1'b0;
      pend_done_r <= 1'b0;
    end else if (out_free) begin
      if (pend_done_r) begin
        vld_r       <= 1'b1;
        pend_done_r <= 1'b0;
      end else if (q_not_empty) begin
        vld_r       <= 1'b1;
        pend_done_r <= q_head.char_vld && q_head.done;
      end else begin
        vld_r <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (pend_done_r) begin
        char_r  <= '0;
        cvld_r  <= 1'b0;
        done_r  <= 1'b1;
        found_r <= pend_found_r;
      end else if (q_not_empty) begin
        pend_found_r <= q_head.found;
        if (q_head.char_vld) begin
          char_r  <= q_head.value_char;
          cvld_r  <= 1'b1;
          done_r  <= 1'b0;
          found_r <= 1'b0;
        end else begin
          char_r  <= '0;
          cvld_r  <= 1'b0;
          done_r  <= 1'b1;
          found_r <= q_head.found;
        end
      end
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {7'd0, found_r, char_r};
  assign out_tuser  = cvld_r;
  assign out_tlast  = done_r;

endmodule
